[hdl/swd_pkg.sv]
// Package with the word types, phase codes and protocol constants of the SWD host engine.
`timescale 1ns / 1ps
package swd_pkg;

  localparam int unsigned LINE_RESET_ONES = 56;

  // Engine phases.
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_HEADER  = 4'd1;
  localparam logic [3:0] PH_TA_ACK  = 4'd2;
  localparam logic [3:0] PH_ACK     = 4'd3;
  localparam logic [3:0] PH_TA_WR   = 4'd4;
  localparam logic [3:0] PH_WDATA   = 4'd5;
  localparam logic [3:0] PH_WPAR    = 4'd6;
  localparam logic [3:0] PH_RDATA   = 4'd7;
  localparam logic [3:0] PH_RPAR    = 4'd8;
  localparam logic [3:0] PH_TA_END  = 4'd9;
  localparam logic [3:0] PH_DRAIN   = 4'd10;
  localparam logic [3:0] PH_LRESET  = 4'd11;
  localparam logic [3:0] PH_IDLECLK = 4'd12;
  localparam logic [3:0] PH_GAP     = 4'd13;

  // Command operations.
  localparam logic [1:0] OP_TRANSFER = 2'd0;
  localparam logic [1:0] OP_LRESET   = 2'd1;
  localparam logic [1:0] OP_IDLE     = 2'd2;

  // Acknowledge codes, first sampled bit in bit 0.
  localparam logic [2:0] ACK_OK    = 3'd1;
  localparam logic [2:0] ACK_WAIT  = 3'd2;
  localparam logic [2:0] ACK_FAULT = 3'd4;
  localparam logic [2:0] ACK_NONE  = 3'd7;

  // Completion status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_WAIT   = 3'd1;
  localparam logic [2:0] ST_FAULT  = 3'd2;
  localparam logic [2:0] ST_PARITY = 3'd3;
  localparam logic [2:0] ST_PROTO  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] CFG_TURNAROUND  = 2'd1;
  localparam logic [1:0] CFG_RETRY_GAP   = 2'd2;

  // Position of the RnW bit in the header byte.
  localparam int unsigned HDR_RNW_BIT = 2;

  typedef struct packed {
    logic        cmd_valid;
    logic [1:0]  operation;
    logic        ap_not_dp;
    logic        read_not_write;
    logic [3:0]  reg_addr;
    logic [31:0] write_data;
    logic [15:0] idle_count;
    logic        swdio_in;
  } in_t;

  typedef struct packed {
    logic        swdio_out;
    logic        swdio_drive;
    logic        clock_active;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] read_data;
    logic [2:0]  last_ack;
  } out_t;

  typedef struct packed {
    logic [7:0]  retry_limit;
    logic [2:0]  turnaround_cycles;
    logic [15:0] retry_gap_cycles;
  } cfg_t;

endpackage

[hdl/swd_host_transaction_engine.sv]
// Top level of the SWD host engine: configuration registers, handshakes and result register.
// The result word for an input word is registered and presented in the cycle after it is accepted.
// Throughput: one input word per cycle; each word is one SWCLK bit time, and the next
// word is taken in the same cycle the held result is taken by the consumer.
// Reset (rst_n low, synchronous): engine idle, all engine state zero, no result pending,
// retry_limit 5, turnaround_cycles 1, retry_gap_cycles 100.
`timescale 1ns / 1ps
module swd_host_transaction_engine
  import swd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg_r;
  out_t res;
  out_t out_r;
  logic out_valid_r;
  logic step;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit       <= 8'd5;
      cfg_r.turnaround_cycles <= 3'd1;
      cfg_r.retry_gap_cycles  <= 16'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RETRY_LIMIT: cfg_r.retry_limit       <= cfg_data[7:0];
        CFG_TURNAROUND:  cfg_r.turnaround_cycles <= cfg_data[2:0];
        CFG_RETRY_GAP:   cfg_r.retry_gap_cycles  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  swd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .word_in (in_data),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hdl/swd_core.sv]
// Bit-level SWD host engine: state registers and the per-bit step logic.
`timescale 1ns / 1ps
module swd_core
  import swd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  in_t  word_in,
  input  cfg_t cfg,
  output out_t res
);

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] cnt;
    logic [31:0] sw;
    logic        par;
    logic [7:0]  att;
    logic [7:0]  hdr;
    logic [31:0] hww;
    logic [2:0]  hst;
    logic [2:0]  hack;
    logic [31:0] hrd;
  } eng_t;

  eng_t st_r, st_nxt;

  function automatic eng_t f_finish(eng_t s, logic [2:0] code);
    s.hst   = code;
    s.phase = PH_IDLE;
    s.cnt   = '0;
    return s;
  endfunction

  function automatic eng_t f_start_attempt(eng_t s);
    s.att   = s.att - 8'd1;
    s.phase = PH_HEADER;
    s.cnt   = 16'd8;
    return s;
  endfunction

  function automatic eng_t f_enter_ack(eng_t s);
    s.phase = PH_ACK;
    s.cnt   = 16'd3;
    s.sw    = '0;
    return s;
  endfunction

  function automatic eng_t f_enter_wdata(eng_t s);
    s.phase = PH_WDATA;
    s.cnt   = 16'd32;
    s.sw    = s.hww;
    s.par   = 1'b0;
    return s;
  endfunction

  function automatic eng_t f_enter_rdata(eng_t s);
    s.phase = PH_RDATA;
    s.cnt   = 16'd32;
    s.sw    = '0;
    s.par   = 1'b0;
    return s;
  endfunction

  function automatic eng_t f_end_exchange(eng_t s, cfg_t c);
    if (s.hack == ACK_OK) begin
      if (s.hdr[HDR_RNW_BIT]) begin
        if (s.par) begin
          s = f_finish(s, ST_PARITY);
        end else begin
          s.hrd = s.sw;
          s = f_finish(s, ST_OK);
        end
      end else begin
        s = f_finish(s, ST_OK);
      end
    end else if (s.hack == ACK_WAIT) begin
      if (s.att == 8'd0) begin
        s = f_finish(s, ST_WAIT);
      end else if (c.retry_gap_cycles != 16'd0) begin
        s.phase = PH_GAP;
        s.cnt   = c.retry_gap_cycles;
      end else begin
        s = f_start_attempt(s);
      end
    end else begin
      s = f_finish(s, ST_FAULT);
    end
    return s;
  endfunction

  // A turnaround_cycles setting of zero falls straight through to what follows it.
  function automatic eng_t f_enter_ta(eng_t s, logic [3:0] ta_ph, cfg_t c);
    if (c.turnaround_cycles == 3'd0) begin
      if (ta_ph == PH_TA_ACK) begin
        s = f_enter_ack(s);
      end else if (ta_ph == PH_TA_WR) begin
        s = f_enter_wdata(s);
      end else begin
        s = f_end_exchange(s, c);
      end
    end else begin
      s.phase = ta_ph;
      s.cnt   = 16'(c.turnaround_cycles);
    end
    return s;
  endfunction

  function automatic eng_t f_after_ack(eng_t s, cfg_t c);
    s.hack = s.sw[2:0];
    if (s.hack == ACK_OK) begin
      if (s.hdr[HDR_RNW_BIT]) begin
        s = f_enter_rdata(s);
      end else begin
        s = f_enter_ta(s, PH_TA_WR, c);
      end
    end else if (s.hack == ACK_WAIT || s.hack == ACK_FAULT) begin
      s = f_enter_ta(s, PH_TA_END, c);
    end else if (s.hack == ACK_NONE) begin
      // Nobody answered: clock out the data phase released, then reset the line.
      s.phase = PH_DRAIN;
      s.cnt   = 16'(c.turnaround_cycles) + 16'd33;
    end else begin
      s = f_finish(s, ST_PROTO);
    end
    return s;
  endfunction

  logic       started;
  logic [3:0] p;
  logic       sdo, drv, sclk, hpar;
  logic [2:0] hbit;
  logic [1:0] abit;

  always_comb begin
    st_nxt  = st_r;
    started = 1'b0;
    sdo     = 1'b0;
    drv     = 1'b1;
    sclk    = 1'b0;
    hpar    = word_in.ap_not_dp ^ word_in.read_not_write
              ^ word_in.reg_addr[2] ^ word_in.reg_addr[3];

    if (st_r.phase == PH_IDLE && word_in.cmd_valid) begin
      case (word_in.operation)
        OP_TRANSFER: begin
          started    = 1'b1;
          st_nxt.hdr = {1'b1, 1'b0, hpar, word_in.reg_addr[3], word_in.reg_addr[2],
                        word_in.read_not_write, word_in.ap_not_dp, 1'b1};
          st_nxt.hww = word_in.write_data;
          st_nxt.att = cfg.retry_limit;
          if (cfg.retry_limit == 8'd0) begin
            st_nxt = f_finish(st_nxt, ST_WAIT);
          end else begin
            st_nxt = f_start_attempt(st_nxt);
          end
        end
        OP_LRESET: begin
          started      = 1'b1;
          st_nxt.hdr   = '0;
          st_nxt.phase = PH_LRESET;
          st_nxt.cnt   = 16'(LINE_RESET_ONES);
        end
        OP_IDLE: begin
          started    = 1'b1;
          st_nxt.hdr = '0;
          if (word_in.idle_count == 16'd0) begin
            st_nxt = f_finish(st_nxt, ST_OK);
          end else begin
            st_nxt.phase = PH_IDLECLK;
            st_nxt.cnt   = word_in.idle_count;
          end
        end
        default: begin
        end
      endcase
    end

    p    = st_nxt.phase;
    hbit = 3'(3'd0 - st_nxt.cnt[2:0]);
    abit = 2'(2'd3 - st_nxt.cnt[1:0]);

    if (p != PH_IDLE) begin
      sclk = 1'b1;
      case (p)
        PH_HEADER: sdo = st_nxt.hdr[hbit];
        PH_ACK: begin
          drv = 1'b0;
          st_nxt.sw[abit] = st_nxt.sw[abit] | word_in.swdio_in;
        end
        PH_WDATA: begin
          sdo        = st_nxt.sw[0];
          st_nxt.sw  = {1'b0, st_nxt.sw[31:1]};
          st_nxt.par = st_nxt.par ^ sdo;
        end
        PH_WPAR:    sdo = st_nxt.par;
        PH_RDATA: begin
          drv        = 1'b0;
          st_nxt.sw  = {word_in.swdio_in, st_nxt.sw[31:1]};
          st_nxt.par = st_nxt.par ^ word_in.swdio_in;
        end
        PH_RPAR: begin
          drv        = 1'b0;
          st_nxt.par = st_nxt.par ^ word_in.swdio_in;
        end
        PH_LRESET:  sdo = 1'b1;
        PH_IDLECLK: sdo = 1'b0;
        PH_GAP:     sclk = 1'b0;
        default:    drv = 1'b0;
      endcase

      st_nxt.cnt = st_nxt.cnt - 16'd1;
      if (st_nxt.cnt == 16'd0) begin
        case (p)
          PH_HEADER:  st_nxt = f_enter_ta(st_nxt, PH_TA_ACK, cfg);
          PH_TA_ACK:  st_nxt = f_enter_ack(st_nxt);
          PH_ACK:     st_nxt = f_after_ack(st_nxt, cfg);
          PH_TA_WR:   st_nxt = f_enter_wdata(st_nxt);
          PH_WDATA: begin
            st_nxt.phase = PH_WPAR;
            st_nxt.cnt   = 16'd1;
          end
          PH_WPAR:    st_nxt = f_end_exchange(st_nxt, cfg);
          PH_RDATA: begin
            st_nxt.phase = PH_RPAR;
            st_nxt.cnt   = 16'd1;
          end
          PH_RPAR:    st_nxt = f_enter_ta(st_nxt, PH_TA_END, cfg);
          PH_TA_END:  st_nxt = f_end_exchange(st_nxt, cfg);
          PH_DRAIN: begin
            st_nxt.phase = PH_LRESET;
            st_nxt.cnt   = 16'(LINE_RESET_ONES);
          end
          // A line reset entered from a transfer ends that transfer as a protocol error.
          PH_LRESET:  st_nxt = f_finish(st_nxt, (st_nxt.hdr != 8'd0) ? ST_PROTO : ST_OK);
          PH_IDLECLK: st_nxt = f_finish(st_nxt, ST_OK);
          PH_GAP:     st_nxt = f_start_attempt(st_nxt);
          default:    st_nxt = f_finish(st_nxt, ST_PROTO);
        endcase
      end
    end
  end

  always_comb begin
    res.swdio_out    = sdo;
    res.swdio_drive  = drv;
    res.clock_active = sclk;
    res.busy_res     = (st_nxt.phase != PH_IDLE);
    res.done_res     = (started || st_r.phase != PH_IDLE) && st_nxt.phase == PH_IDLE;
    res.status       = st_nxt.hst;
    res.read_data    = st_nxt.hrd;
    res.last_ack     = st_nxt.hack;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= '0;
      st_r.phase <= PH_IDLE;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

`ifndef SYNTH
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step && st_r.phase == PH_IDLE && !word_in.cmd_valid |=> st_r.phase == PH_IDLE)
    else $error("engine left idle without a command");

  a_state_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(st_r))
    else $error("engine state moved without an accepted word");

  a_gap_no_clock: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_GAP |-> !res.clock_active && res.swdio_drive)
    else $error("clock pulse or released line during retry gap");

  a_ack_released: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_ACK |-> !res.swdio_drive && !res.swdio_out)
    else $error("host drives the line while sampling the acknowledge");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.done_res |-> !res.busy_res)
    else $error("done reported while still busy");
`endif

endmodule
